// File: rtl/usbp_pkg.sv
`timescale 1ns / 1ps
package usbp_pkg;

    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int OUT_FRAC_BITS_DEF = 30;

    // iteration counts of the shared stage chain
    localparam int ITER_STAGES  = 32;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd1304065748;
    localparam logic signed [33:0] ONE_Q31     = 34'sh0_8000_0000;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // payload carried through the iteration stages
    typedef struct packed {
        logic               op;
        logic [31:0]        rs;
        logic [31:0]        h;
        logic [63:0]        sq_rem;
        logic [63:0]        sq_res;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [31:0] ang;
        logic [1:0]         quad;
        logic [69:0]        cb_rem;
        logic [31:0]        cb_y;
        logic [63:0]        cb_y2;
    } t_iter;

    // right shift by n (n >= 1), rounded to nearest, ties away from zero
    function automatic logic signed [63:0] f_rshift(input logic signed [63:0] v,
                                                   input int unsigned n);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -signed'(mag) : signed'(mag);
    endfunction

endpackage

// File: rtl/usbp_if.sv
`timescale 1ns / 1ps
interface usbp_smp_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] radius_sample;
    logic [31:0] height_sample;
    logic [31:0] angle_sample;
    modport source(output valid, op, radius_sample, height_sample, angle_sample,
                   input ready);
    modport sink(input valid, op, radius_sample, height_sample, angle_sample,
                 output ready);
endinterface

interface usbp_pnt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    modport source(output valid, coord_x, coord_y, coord_z, input ready);
    modport sink(input valid, coord_x, coord_y, coord_z, output ready);
endinterface

// File: rtl/usbp_iter.sv
`timescale 1ns / 1ps
module usbp_iter #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  usbp_pkg::t_iter i_d,
    output logic            o_vld,
    output usbp_pkg::t_iter o_d
);
    import usbp_pkg::*;

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * IDX);
    localparam int          CB_GRP = 3 * (ITER_STAGES - 1 - IDX);

    logic        r_vld;
    t_iter       r_d;
    t_iter       n_d;
    logic [63:0] w_sq_sum;
    logic [95:0] w_cb_n;
    logic [2:0]  w_cb_dig;
    logic [69:0] w_cb_rem;
    logic [69:0] w_cb_trial;

    always_comb begin
        n_d = i_d;

        // square root, one result bit per stage
        w_sq_sum = i_d.sq_res + SQ_BIT;
        if (i_d.sq_rem >= w_sq_sum) begin
            n_d.sq_rem = i_d.sq_rem - w_sq_sum;
            n_d.sq_res = (i_d.sq_res >> 1) + SQ_BIT;
        end else begin
            n_d.sq_res = i_d.sq_res >> 1;
        end

        // cordic rotation step
        if (IDX < CORDIC_STEPS) begin
            if (!i_d.ang[31]) begin
                n_d.cx  = i_d.cx - (i_d.cy >>> IDX);
                n_d.cy  = i_d.cy + (i_d.cx >>> IDX);
                n_d.ang = i_d.ang - signed'(ATAN_TURNS[IDX]);
            end else begin
                n_d.cx  = i_d.cx + (i_d.cy >>> IDX);
                n_d.cy  = i_d.cy - (i_d.cx >>> IDX);
                n_d.ang = i_d.ang + signed'(ATAN_TURNS[IDX]);
            end
        end

        // cube root of radius * 2^64, three radicand bits per stage
        w_cb_n     = {i_d.rs, 64'd0};
        w_cb_dig   = 3'(w_cb_n >> CB_GRP);
        w_cb_rem   = (i_d.cb_rem << 3) | 70'(w_cb_dig);
        w_cb_trial = 70'(i_d.cb_y2) * 70'd12 + 70'(i_d.cb_y) * 70'd6 + 70'd1;
        if (w_cb_rem >= w_cb_trial) begin
            n_d.cb_rem = w_cb_rem - w_cb_trial;
            n_d.cb_y   = (i_d.cb_y << 1) | 32'd1;
            n_d.cb_y2  = (i_d.cb_y2 << 2) + (64'(i_d.cb_y) << 2) + 64'd1;
        end else begin
            n_d.cb_rem = w_cb_rem;
            n_d.cb_y   = i_d.cb_y << 1;
            n_d.cb_y2  = i_d.cb_y2 << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// File: rtl/unit_sphere_ball_point_mapper.sv
`timescale 1ns / 1ps
// structure: an input register, then the 32-stage square root and cube root
// chains that run beside the cordic stages, then post stages a to e
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// reset: synchronous, active low, clears the stage valid bits only
module unit_sphere_ball_point_mapper #(
    parameter int SAMPLE_BITS   = usbp_pkg::SAMPLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = usbp_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    usbp_smp_if.sink    i_smp,
    usbp_pnt_if.source  o_pnt
);
    import usbp_pkg::*;

    localparam int          SMP_SHR = (SAMPLE_BITS >= 32) ? SAMPLE_BITS - 32 : 0;
    localparam int          SMP_SHL = (SAMPLE_BITS < 32) ? 32 - SAMPLE_BITS : 0;
    localparam int unsigned SPH_RS  = (OUT_FRAC_BITS < 31) ? 31 - OUT_FRAC_BITS : 1;
    localparam int unsigned SPH_LS  = (OUT_FRAC_BITS > 31) ? OUT_FRAC_BITS - 31 : 0;
    localparam int unsigned BALL_RS = 63 - OUT_FRAC_BITS;

    logic w_en;

    // input stage
    logic        r_v0;
    t_iter       r_s0;
    t_iter       n_s0;
    logic [31:0] w_rs;
    logic [31:0] w_h;
    logic [31:0] w_a;
    logic [31:0] w_shifted;
    logic [63:0] w_hh;

    // iteration chain
    logic  w_vld [ITER_STAGES + 1];
    t_iter w_d   [ITER_STAGES + 1];

    // post stages: valid bits
    logic [4:0] r_pv;

    // stage a: finish root, clamp and rotate quadrant
    logic               r_a_op;
    logic [31:0]        r_a_h;
    logic [31:0]        r_a_scale;
    logic signed [32:0] r_a_c;
    logic signed [32:0] r_a_s;
    logic [31:0]        r_a_r;
    logic signed [32:0] n_a_c;
    logic signed [32:0] n_a_s;
    logic signed [32:0] w_xc;
    logic signed [32:0] w_yc;
    logic [63:0]        w_sq_fin;

    // stage b: products with radius
    logic               r_b_op;
    logic [31:0]        r_b_h;
    logic [31:0]        r_b_scale;
    logic signed [63:0] r_b_px;
    logic signed [63:0] r_b_py;
    logic signed [65:0] w_px;
    logic signed [65:0] w_py;

    // stage c: rounded sphere coordinates
    logic               r_c_op;
    logic [31:0]        r_c_h;
    logic [31:0]        r_c_scale;
    logic signed [32:0] r_c_vx;
    logic signed [32:0] r_c_vy;
    logic signed [32:0] r_c_vz;
    logic signed [63:0] w_rx;
    logic signed [63:0] w_ry;

    // stage d: ball scaling, sphere points pass unscaled
    logic               r_d_op;
    logic signed [63:0] r_d_wx;
    logic signed [63:0] r_d_wy;
    logic signed [63:0] r_d_wz;
    logic signed [65:0] w_bx;
    logic signed [65:0] w_by;
    logic signed [65:0] w_bz;

    // stage e: output register
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;
    logic signed [31:0] r_oz;
    logic signed [63:0] w_ox;
    logic signed [63:0] w_oy;
    logic signed [63:0] w_oz;

    // the pipeline advances whenever the output slot is free or taken
    assign w_en        = !r_pv[4] || o_pnt.ready;
    assign i_smp.ready = w_en;

    // sample conversion and iteration seeds
    always_comb begin
        w_rs      = (i_smp.radius_sample << SMP_SHL) >> SMP_SHR;
        w_h       = (i_smp.height_sample << SMP_SHL) >> SMP_SHR;
        w_a       = (i_smp.angle_sample << SMP_SHL) >> SMP_SHR;
        w_shifted = w_a + 32'h2000_0000;
        // h * (2^32 - h) as h * 2^32 - h^2
        w_hh      = w_h * w_h;
        n_s0        = '0;
        n_s0.op     = i_smp.op;
        n_s0.rs     = w_rs;
        n_s0.h      = w_h;
        n_s0.sq_rem = {w_h, 32'd0} - w_hh;
        n_s0.cx     = CORDIC_GAIN;
        n_s0.quad   = w_shifted[31:30];
        n_s0.ang    = signed'({2'b00, w_shifted[29:0]}) - 32'sh2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    assign w_vld[0] = r_v0;
    assign w_d[0]   = r_s0;

    // iteration stages
    for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
        usbp_iter #(.IDX(k)) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[k]),
            .i_d     (w_d[k]),
            .o_vld   (w_vld[k + 1]),
            .o_d     (w_d[k + 1])
        );
    end

    // root rounding, clamp to unit range and quadrant mapping
    always_comb begin
        w_sq_fin = w_d[ITER_STAGES].sq_res +
                   64'(w_d[ITER_STAGES].sq_rem > w_d[ITER_STAGES].sq_res);
        if (w_d[ITER_STAGES].cx > ONE_Q31) begin
            w_xc = 33'(ONE_Q31);
        end else if (w_d[ITER_STAGES].cx < -ONE_Q31) begin
            w_xc = 33'(-ONE_Q31);
        end else begin
            w_xc = 33'(w_d[ITER_STAGES].cx);
        end
        if (w_d[ITER_STAGES].cy > ONE_Q31) begin
            w_yc = 33'(ONE_Q31);
        end else if (w_d[ITER_STAGES].cy < -ONE_Q31) begin
            w_yc = 33'(-ONE_Q31);
        end else begin
            w_yc = 33'(w_d[ITER_STAGES].cy);
        end
        case (w_d[ITER_STAGES].quad)
            2'd0: begin
                n_a_c = w_xc;
                n_a_s = w_yc;
            end
            2'd1: begin
                n_a_c = -w_yc;
                n_a_s = w_xc;
            end
            2'd2: begin
                n_a_c = -w_xc;
                n_a_s = -w_yc;
            end
            default: begin
                n_a_c = w_yc;
                n_a_s = -w_xc;
            end
        endcase
    end

    // radius products
    assign w_px = r_a_c * signed'({1'b0, r_a_r});
    assign w_py = r_a_s * signed'({1'b0, r_a_r});

    // back to q1.31
    assign w_rx = f_rshift(r_b_px, 31);
    assign w_ry = f_rshift(r_b_py, 31);

    // ball scale
    assign w_bx = r_c_vx * signed'({1'b0, r_c_scale});
    assign w_by = r_c_vy * signed'({1'b0, r_c_scale});
    assign w_bz = r_c_vz * signed'({1'b0, r_c_scale});

    // output format
    always_comb begin
        if (r_d_op) begin
            w_ox = f_rshift(r_d_wx, BALL_RS);
            w_oy = f_rshift(r_d_wy, BALL_RS);
            w_oz = f_rshift(r_d_wz, BALL_RS);
        end else if (OUT_FRAC_BITS < 31) begin
            w_ox = f_rshift(r_d_wx, SPH_RS);
            w_oy = f_rshift(r_d_wy, SPH_RS);
            w_oz = f_rshift(r_d_wz, SPH_RS);
        end else begin
            w_ox = r_d_wx <<< SPH_LS;
            w_oy = r_d_wy <<< SPH_LS;
            w_oz = r_d_wz <<< SPH_LS;
        end
    end

    // post stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[3:0], w_vld[ITER_STAGES]};
        end
    end

    // post stage payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_op    <= w_d[ITER_STAGES].op;
            r_a_h     <= w_d[ITER_STAGES].h;
            r_a_scale <= w_d[ITER_STAGES].cb_y;
            r_a_c     <= n_a_c;
            r_a_s     <= n_a_s;
            r_a_r     <= w_sq_fin[31:0];

            r_b_op    <= r_a_op;
            r_b_h     <= r_a_h;
            r_b_scale <= r_a_scale;
            r_b_px    <= w_px[63:0];
            r_b_py    <= w_py[63:0];

            r_c_op    <= r_b_op;
            r_c_h     <= r_b_h;
            r_c_scale <= r_b_scale;
            r_c_vx    <= w_rx[32:0];
            r_c_vy    <= w_ry[32:0];
            r_c_vz    <= 33'sh0_8000_0000 - signed'({1'b0, r_b_h});

            r_d_op    <= r_c_op;
            r_d_wx    <= r_c_op ? w_bx[63:0] : 64'(r_c_vx);
            r_d_wy    <= r_c_op ? w_by[63:0] : 64'(r_c_vy);
            r_d_wz    <= r_c_op ? w_bz[63:0] : 64'(r_c_vz);

            r_ox      <= w_ox[31:0];
            r_oy      <= w_oy[31:0];
            r_oz      <= w_oz[31:0];
        end
    end

    assign o_pnt.valid   = r_pv[4];
    assign o_pnt.coord_x = r_ox;
    assign o_pnt.coord_y = r_oy;
    assign o_pnt.coord_z = r_oz;

    // rotated cosine and sine stay on the unit range
    a_unit_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[0] |-> (r_a_c <= 33'sh0_8000_0000 && r_a_c >= -33'sh0_8000_0000 &&
                     r_a_s <= 33'sh0_8000_0000 && r_a_s >= -33'sh0_8000_0000))
        else $error("cos/sin out of unit range");

    // horizontal radius never exceeds one
    a_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[0] |-> r_a_r <= 32'h8000_0000)
        else $error("horizontal radius above one");

    // zero height puts the point on the pole
    a_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv[2] && r_c_h == 32'd0) |-> (r_c_vx == 33'sd0 && r_c_vy == 33'sd0))
        else $error("pole point off axis");

    // a stalled result is not replaced (checked on x and z)
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv[4] && !o_pnt.ready) |=> (r_pv[4] && $stable(r_ox) && $stable(r_oz)))
        else $error("stalled result changed");

endmodule
